// ----- hdl/bam_pkg.sv -----
`timescale 1ns / 1ps

package bam_pkg;

  localparam int MAX_COLS  = 256;
  localparam int MAX_BLOCK = 64;
  localparam int MAX_WIDTH = 4096;
  localparam int MAX_ROWS  = 1024;
  localparam int MEAN_STEP = 18;

  localparam int GRAY_W      = 8;
  localparam int GLYPH_W     = 7;
  localparam int BLOCK_COL_W = 8;
  localparam int BLOCK_ROW_W = 10;
  localparam int SUM_W       = 20;
  localparam int COL_W       = $clog2(MAX_COLS);

  localparam int IW_W   = 13;
  localparam int BS_W   = 7;
  localparam int COLS_W = 9;
  localparam int ROWS_W = 11;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH = 2'd0,
    REG_BLOCK_SIZE  = 2'd1,
    REG_OUT_COLS    = 2'd2,
    REG_OUT_ROWS    = 2'd3
  } cfg_reg_t;

  localparam logic [GLYPH_W-1:0] GLYPHS [15] = '{
    7'h4D, 7'h4E, 7'h48, 7'h51, 7'h24, 7'h4F, 7'h43, 7'h3F,
    7'h37, 7'h3E, 7'h21, 7'h3A, 7'h2D, 7'h3B, 7'h2E
  };

  // The table index is mean / 18, found by counting the step thresholds passed.
  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [GRAY_W-1:0] mean);
    logic [3:0] idx;
    idx = '0;
    for (int k = 1; k < 15; k++) begin
      if (mean >= GRAY_W'(k * MEAN_STEP)) begin
        idx = idx + 4'd1;
      end
    end
    return GLYPHS[idx];
  endfunction

endpackage

// ----- hdl/bam_if.sv -----
`timescale 1ns / 1ps

interface bam_pix_if import bam_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray;
  logic              frame_start;

  modport source (output valid, output gray, output frame_start, input ready);
  modport sink (input valid, input gray, input frame_start, output ready);
endinterface

interface bam_res_if import bam_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [GLYPH_W-1:0]     glyph;
  logic [GRAY_W-1:0]      block_mean;
  logic [BLOCK_COL_W-1:0] block_col;
  logic [BLOCK_ROW_W-1:0] block_row;
  logic                   frame_done;

  modport source (
    output valid, output glyph, output block_mean, output block_col,
    output block_row, output frame_done, input ready
  );
  modport sink (
    input valid, input glyph, input block_mean, input block_col,
    input block_row, input frame_done, output ready
  );
endinterface

interface bam_cfg_if import bam_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/box_average_ascii_art_mapper.sv -----
`timescale 1ns / 1ps

// Box-average downscaler that turns a gray raster into ASCII glyphs.
// Pixels enter on the pix channel in raster order; frame_start on a word
// restarts the frame counters and drops all partial sums. One word leaves on
// the res channel for every completed block: glyph, rounded mean, block
// column and row, and frame_done on the last block of the frame.
// Configuration goes through the cfg channel at indices 0..3 (image_width,
// block_size, out_cols, out_rows), all 1 after reset.
// Throughput is one pixel per cycle while the divider is idle. The pixel that
// completes a block holds the input while the shared bit-serial divider forms
// the mean; a saturated mean skips the division. Column sums sit in a
// 256-entry RAM, read as the pixel is taken and written back from stage two,
// with forwarding. A block_size write makes the divider rebuild the column
// position from pixel_x, during which pix and cfg are held off.
// Reset restores the registers and clears the counters and the sum valid
// bits. A stalled receiver holds the result register; pixels keep flowing
// until the next completed block needs the output.

module box_average_ascii_art_mapper import bam_pkg::*; (
  input logic        clk,
  input logic        rst,
  bam_pix_if.sink    pix,
  bam_res_if.source  res,
  bam_cfg_if.sink    cfg
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_OUT} div_state_t;
  typedef enum logic {JOB_MEAN, JOB_POS} div_job_t;

  typedef struct packed {
    logic                   start;
    logic                   wr;
    logic                   complete;
    logic                   row_clear;
    logic                   last;
    logic [COL_W-1:0]       col;
    logic [GRAY_W-1:0]      gray;
    logic [BLOCK_ROW_W-1:0] row;
  } s2_t;

  localparam logic [IW_W-1:0]   IW_MAX   = IW_W'(MAX_WIDTH);
  localparam logic [BS_W-1:0]   BS_MAX   = BS_W'(MAX_BLOCK);
  localparam logic [COLS_W-1:0] COLS_MAX = COLS_W'(MAX_COLS);
  localparam logic [ROWS_W-1:0] ROWS_MAX = ROWS_W'(MAX_ROWS);
  localparam int DIV_W = SUM_W + 1;

  logic [IW_W-1:0]   image_width;
  logic [BS_W-1:0]   block_size;
  logic [COLS_W-1:0] out_cols;
  logic [ROWS_W-1:0] out_rows;
  logic [IW_W-1:0]   iw_eff;
  logic [BS_W-1:0]   bs_eff;
  logic [COLS_W-1:0] cols_eff;
  logic [ROWS_W-1:0] rows_eff;
  logic [12:0]       n_r;

  logic [11:0]       pixel_x;
  logic [5:0]        line_in_block;
  logic [ROWS_W-1:0] block_row_count;
  logic [11:0]       bcol;
  logic [5:0]        col_off;

  logic [SUM_W-1:0]    col_mem [MAX_COLS];
  logic [SUM_W-1:0]    rd_data;
  logic [MAX_COLS-1:0] colv;
  logic [MAX_COLS-1:0] colv_next;
  logic                wr_last_en;
  logic [COL_W-1:0]    wr_last_addr;
  logic [SUM_W-1:0]    wr_last_data;

  logic s2_valid;
  s2_t  s2;
  s2_t  s2_next;

  div_state_t             dstate;
  div_job_t               djob;
  logic [DIV_W-1:0]       div_rem;
  logic [DIV_W-1:0]       div_dsh;
  logic [11:0]            div_q;
  logic [3:0]             div_cnt;
  logic                   recalc_pend;
  logic [BLOCK_COL_W-1:0] div_col;
  logic [BLOCK_ROW_W-1:0] div_row;
  logic                   div_last;

  logic                   out_valid;
  logic [GLYPH_W-1:0]     out_glyph;
  logic [GRAY_W-1:0]      out_mean;
  logic [BLOCK_COL_W-1:0] out_col;
  logic [BLOCK_ROW_W-1:0] out_row;
  logic                   out_last;

  logic pix_take;
  logic cfg_take;

  logic              st;
  logic [11:0]       px;
  logic [5:0]        lib;
  logic [ROWS_W-1:0] brc;
  logic [11:0]       bc;
  logic [5:0]        wi;
  logic              active;
  logic              in_col;
  logic [BS_W-1:0]   bsm1;
  logic [IW_W-1:0]   px_inc;
  logic [BS_W-1:0]   lib_inc;
  logic [BS_W-1:0]   wi_inc;
  logic              line_end;
  logic              row_end;
  logic [11:0]       px_n;
  logic [5:0]        lib_n;
  logic [ROWS_W-1:0] brc_n;
  logic [11:0]       bc_n;
  logic [5:0]        wi_n;

  logic             fwd_hit;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] sum;
  logic             s2_done;
  logic [DIV_W-1:0] dividend;

  logic             fits;
  logic [DIV_W-1:0] rem_step;
  logic [11:0]      q_step;
  logic             pos_done;

  always_comb begin
    iw_eff = (image_width == '0) ? IW_W'(1) : ((image_width > IW_MAX) ? IW_MAX : image_width);
    bs_eff = (block_size == '0) ? BS_W'(1) : ((block_size > BS_MAX) ? BS_MAX : block_size);
    cols_eff = (out_cols == '0) ? COLS_W'(1) : ((out_cols > COLS_MAX) ? COLS_MAX : out_cols);
    rows_eff = (out_rows == '0) ? ROWS_W'(1) : ((out_rows > ROWS_MAX) ? ROWS_MAX : out_rows);
  end

  assign pix.ready = (dstate == D_IDLE) && !recalc_pend && !s2_done;
  assign cfg.ready = (dstate == D_IDLE) && !recalc_pend;
  assign pix_take  = pix.valid && pix.ready;
  assign cfg_take  = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IW_W'(1);
      block_size  <= BS_W'(1);
      out_cols    <= COLS_W'(1);
      out_rows    <= ROWS_W'(1);
    end else if (cfg_take) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_IMAGE_WIDTH: image_width <= cfg.data[IW_W-1:0];
        REG_BLOCK_SIZE:  block_size  <= cfg.data[BS_W-1:0];
        REG_OUT_COLS:    out_cols    <= cfg.data[COLS_W-1:0];
        REG_OUT_ROWS:    out_rows    <= cfg.data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    n_r <= {6'd0, bs_eff} * {6'd0, bs_eff};
  end

  // Stage one: position bookkeeping for the accepted pixel.
  always_comb begin
    st      = pix.frame_start;
    px      = st ? '0 : pixel_x;
    lib     = st ? '0 : line_in_block;
    brc     = st ? '0 : block_row_count;
    bc      = st ? '0 : bcol;
    wi      = st ? '0 : col_off;
    active  = brc < rows_eff;
    in_col  = bc < {3'b000, cols_eff};
    bsm1    = bs_eff - BS_W'(1);
    px_inc  = {1'b0, px} + IW_W'(1);
    lib_inc = {1'b0, lib} + BS_W'(1);
    wi_inc  = {1'b0, wi} + BS_W'(1);
    line_end = px_inc >= iw_eff;
    row_end  = line_end && (lib_inc >= bs_eff);
    px_n  = px_inc[11:0];
    lib_n = lib;
    brc_n = brc;
    bc_n  = bc;
    wi_n  = wi_inc[5:0];
    if (line_end) begin
      px_n = '0;
      bc_n = '0;
      wi_n = '0;
      lib_n = row_end ? '0 : lib_inc[5:0];
      brc_n = row_end ? brc + ROWS_W'(1) : brc;
    end else if (wi_inc == bs_eff) begin
      wi_n = '0;
      bc_n = bc + 12'd1;
    end
    s2_next.start     = st;
    s2_next.wr        = in_col;
    s2_next.complete  = in_col && ({1'b0, wi} == bsm1) && ({1'b0, lib} >= bsm1);
    s2_next.row_clear = row_end;
    s2_next.last      = (bc == {3'b000, cols_eff - COLS_W'(1)})
                        && (brc == rows_eff - ROWS_W'(1));
    s2_next.col       = bc[COL_W-1:0];
    s2_next.gray      = pix.gray;
    s2_next.row       = brc[BLOCK_ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_x         <= '0;
      line_in_block   <= '0;
      block_row_count <= '0;
      bcol            <= '0;
      col_off         <= '0;
      s2_valid        <= 1'b0;
    end else begin
      s2_valid <= pix_take && active;
      if (pix_take && active) begin
        pixel_x         <= px_n;
        line_in_block   <= lib_n;
        block_row_count <= brc_n;
        bcol            <= bc_n;
        col_off         <= wi_n;
      end else if (pos_done) begin
        bcol    <= q_step;
        col_off <= rem_step[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      s2      <= s2_next;
      rd_data <= col_mem[s2_next.col];
    end
    if (s2_valid && s2.wr && !s2.complete) begin
      col_mem[s2.col] <= sum;
    end
    wr_last_addr <= s2.col;
    wr_last_data <= sum;
  end

  // Stage two: add the pixel to its column sum and write it back, or hand a completed block to the divider.
  always_comb begin
    fwd_hit  = wr_last_en && (wr_last_addr == s2.col);
    base     = (s2.start || !colv[s2.col]) ? '0 : (fwd_hit ? wr_last_data : rd_data);
    sum      = base + SUM_W'(s2.gray);
    s2_done  = s2_valid && s2.wr && s2.complete;
    dividend = {1'b0, sum} + DIV_W'(n_r[12:1]);
    colv_next = colv;
    if (s2_valid) begin
      if (s2.start) begin
        colv_next = '0;
      end
      if (s2.wr) begin
        colv_next[s2.col] = !s2.complete;
      end
      if (s2.row_clear) begin
        colv_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colv       <= '0;
      wr_last_en <= 1'b0;
    end else begin
      colv       <= colv_next;
      wr_last_en <= s2_valid && s2.wr && !s2.complete;
    end
  end

  always_comb begin
    fits     = div_rem >= div_dsh;
    rem_step = fits ? div_rem - div_dsh : div_rem;
    q_step   = {div_q[10:0], fits};
    pos_done = (dstate == D_RUN) && (djob == JOB_POS) && (div_cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate      <= D_IDLE;
      djob        <= JOB_MEAN;
      recalc_pend <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_take && (cfg_reg_t'(cfg.index) == REG_BLOCK_SIZE)) begin
        recalc_pend <= 1'b1;
      end
      if (out_valid && res.ready && (dstate != D_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (dstate)
        D_IDLE: begin
          if (s2_done) begin
            djob     <= JOB_MEAN;
            div_col  <= BLOCK_COL_W'(s2.col);
            div_row  <= s2.row;
            div_last <= s2.last;
            if (dividend >= {n_r, 8'd0}) begin
              div_q  <= 12'd255;
              dstate <= D_OUT;
            end else begin
              div_q   <= '0;
              div_rem <= dividend;
              div_dsh <= {1'b0, n_r, 7'd0};
              div_cnt <= 4'd7;
              dstate  <= D_RUN;
            end
          end else if (recalc_pend && !s2_valid) begin
            recalc_pend <= 1'b0;
            djob        <= JOB_POS;
            div_q       <= '0;
            div_rem     <= DIV_W'(pixel_x);
            div_dsh     <= {3'b000, bs_eff, 11'd0};
            div_cnt     <= 4'd11;
            dstate      <= D_RUN;
          end
        end
        D_RUN: begin
          div_rem <= rem_step;
          div_q   <= q_step;
          div_dsh <= div_dsh >> 1;
          div_cnt <= div_cnt - 4'd1;
          if (div_cnt == '0) begin
            dstate <= (djob == JOB_MEAN) ? D_OUT : D_IDLE;
          end
        end
        D_OUT: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_glyph <= glyph_of(div_q[7:0]);
            out_mean  <= div_q[7:0];
            out_col   <= div_col;
            out_row   <= div_row;
            out_last  <= div_last;
            dstate    <= D_IDLE;
          end
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

  assign res.valid      = out_valid;
  assign res.glyph      = out_glyph;
  assign res.block_mean = out_mean;
  assign res.block_col  = out_col;
  assign res.block_row  = out_row;
  assign res.frame_done = out_last;

`ifndef SYNTHESIS
  a_done_starts_div: assert property (@(posedge clk) disable iff (rst)
    s2_done |=> dstate != D_IDLE)
    else $error("completed block did not start the divider");

  a_offset_in_block: assert property (@(posedge clk) disable iff (rst)
    (dstate == D_IDLE) && !recalc_pend |-> {1'b0, col_off} < bs_eff)
    else $error("column offset outside the block");

  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2.row_clear |=> colv == '0)
    else $error("column sums not dropped at block row end");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (dstate == D_OUT) && out_valid && !res.ready |=> dstate == D_OUT)
    else $error("result overwrote a pending word");
`endif

endmodule

// ----- dv/box_average_ascii_art_mapper_tb.sv -----
`timescale 1ns / 1ps

module box_average_ascii_art_mapper_tb;
  import bam_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int RX_HOLD      = 250;
  localparam int RANDOM_ITEMS = 250;
  localparam int SETTLE       = 20;

  typedef struct packed {
    logic [GLYPH_W-1:0]     glyph;
    logic [GRAY_W-1:0]      mean;
    logic [BLOCK_COL_W-1:0] col;
    logic [BLOCK_ROW_W-1:0] row;
    logic                   done;
  } block_word_t;

  class block_glyph_model;
    logic [IW_W-1:0]   image_width;
    logic [BS_W-1:0]   block_size;
    logic [COLS_W-1:0] out_cols;
    logic [ROWS_W-1:0] out_rows;
    int unsigned       col_sum [MAX_COLS];
    int unsigned       pixel_x;
    int unsigned       line_in_block;
    int unsigned       block_row;
    block_word_t       pending [$];
    int                errors;
    int                shown;
    string             glyph_chars = "MNHQ$OC?7>!:-;.";

    function new();
      image_width = 1;
      block_size = 1;
      out_cols = 1;
      out_rows = 1;
      clear_frame();
      errors = 0;
      shown = 0;
    endfunction

    function void clear_sums();
      foreach (col_sum[i]) col_sum[i] = 0;
    endfunction

    function void clear_frame();
      clear_sums();
      pixel_x = 0;
      line_in_block = 0;
      block_row = 0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH: image_width = data[IW_W-1:0];
        REG_BLOCK_SIZE:  block_size = data[BS_W-1:0];
        REG_OUT_COLS:    out_cols = data[COLS_W-1:0];
        REG_OUT_ROWS:    out_rows = data[ROWS_W-1:0];
        default: ;
      endcase
    endfunction

    // Returns 1 when the pixel falls inside the frame and moves the counters.
    function bit take_pixel(logic [GRAY_W-1:0] gray, logic start);
      int unsigned iw, bs, cols, rows, bc, in_blk, n, mean, gi;
      block_word_t w;
      byte c;
      iw = clip(image_width, MAX_WIDTH);
      bs = clip(block_size, MAX_BLOCK);
      cols = clip(out_cols, MAX_COLS);
      rows = clip(out_rows, MAX_ROWS);
      if (start) clear_frame();
      if (block_row >= rows) return 1'b0;
      bc = pixel_x / bs;
      in_blk = pixel_x % bs;
      if (bc < cols) begin
        col_sum[bc] = (col_sum[bc] + gray) & 32'hFFFFF;
        if (in_blk == bs - 1 && line_in_block >= bs - 1) begin
          n = bs * bs;
          mean = (col_sum[bc] + n / 2) / n;
          if (mean > 255) mean = 255;
          gi = mean / MEAN_STEP;
          if (gi > 14) gi = 14;
          c = glyph_chars.getc(gi);
          w.glyph = c[GLYPH_W-1:0];
          w.mean = mean[GRAY_W-1:0];
          w.col = bc[BLOCK_COL_W-1:0];
          w.row = block_row[BLOCK_ROW_W-1:0];
          w.done = (bc == cols - 1 && block_row == rows - 1);
          pending.push_back(w);
          col_sum[bc] = 0;
        end
      end
      pixel_x++;
      if (pixel_x >= iw) begin
        pixel_x = 0;
        line_in_block++;
        if (line_in_block >= bs) begin
          line_in_block = 0;
          block_row++;
          clear_sums();
        end
      end
      return 1'b1;
    endfunction

    function void match_block(block_word_t got);
      block_word_t want;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected block: glyph %h mean %0d col %0d row %0d done %b",
                   got.glyph, got.mean, got.col, got.row, got.done);
        end
        return;
      end
      want = pending.pop_front();
      if (got.glyph !== want.glyph || got.mean !== want.mean || got.col !== want.col ||
          got.row !== want.row || got.done !== want.done) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("block mismatch: want glyph %h mean %0d col %0d row %0d done %b",
                   want.glyph, want.mean, want.col, want.row, want.done);
          $display("                got  glyph %h mean %0d col %0d row %0d done %b",
                   got.glyph, got.mean, got.col, got.row, got.done);
        end
      end
    endfunction

    function void close_out();
      if (pending.size() != 0) begin
        errors += pending.size();
        $display("%0d expected blocks never arrived", pending.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bam_pix_if pix ();
  bam_res_if res ();
  bam_cfg_if cfg ();

  box_average_ascii_art_mapper dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  block_glyph_model board = new();
  bit               steady;
  bit               hold_rx;
  int unsigned      used_items;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_pixel(logic [GRAY_W-1:0] g, logic s);
    pix.valid <= 1'b1;
    pix.gray <= g;
    pix.frame_start <= s;
    do @(posedge clk); while (pix.ready !== 1'b1);
    if (board.take_pixel(g, s)) used_items++;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 10) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic stop_pixels();
    pix.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_reg(cfg_reg_t r, int unsigned v);
    cfg.valid <= 1'b1;
    cfg.index <= r;
    cfg.data <= CFG_DATA_W'(v);
    do @(posedge clk); while (cfg.ready !== 1'b1);
    board.write_reg(r, CFG_DATA_W'(v));
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(int unsigned iw, int unsigned bs, int unsigned cols,
                           int unsigned rows);
    set_reg(REG_IMAGE_WIDTH, iw);
    set_reg(REG_BLOCK_SIZE, bs);
    set_reg(REG_OUT_COLS, cols);
    set_reg(REG_OUT_ROWS, rows);
  endtask

  task automatic send_frame(int unsigned count, bit with_start, bit noise,
                            int unsigned pause_at);
    logic [GRAY_W-1:0] g;
    logic              s;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(7))
        0: g = 8'd0;
        1: g = 8'd255;
        default: g = GRAY_W'($urandom_range(255));
      endcase
      s = (k == 0) ? with_start : (noise && $urandom_range(49) == 0);
      if (k == pause_at) begin
        stop_pixels();
        drain();
      end
      send_pixel(g, s);
    end
    stop_pixels();
    drain();
  endtask

  initial begin
    int unsigned hold_left;
    block_word_t got;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        got.glyph = res.glyph;
        got.mean = res.block_mean;
        got.col = res.block_col;
        got.row = res.block_row;
        got.done = res.frame_done;
        board.match_block(got);
      end
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (hold_rx) begin
        hold_rx = 1'b0;
        hold_left = RX_HOLD;
        res.ready <= 1'b0;
      end else begin
        res.ready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((pix.valid === 1'b1 && pix.ready === 1'b1) ||
          (res.valid === 1'b1 && res.ready === 1'b1) ||
          (cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("box_average_ascii_art_mapper_tb: errors");
    $finish;
  end

  initial begin
    int unsigned iw, bs, cols, rows, count, r;
    pix.valid <= 1'b0;
    pix.gray <= '0;
    pix.frame_start <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_IMAGE_WIDTH;
    cfg.data <= '0;
    steady = 1'b0;
    hold_rx = 1'b0;
    used_items = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Registers at reset: every pixel is a whole frame. The first pixel gives a word
    // before any frame start, the second lands after the frame is finished.
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd17, 1'b1);
    send_pixel(8'd18, 1'b1);
    send_pixel(8'd251, 1'b1);
    send_pixel(8'd252, 1'b1);
    stop_pixels();
    drain();

    // 2x2 blocks on a 5-wide line: the third block column is never completed,
    // the first block rounds half up, and the trailing pixel is past the frame.
    configure(5, 2, 3, 1);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd9, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd77, 1'b0);
    send_pixel(8'd128, 1'b0);
    stop_pixels();
    drain();

    // Zero in every register acts as one.
    configure(0, 0, 0, 0);
    send_pixel(8'd90, 1'b1);
    send_pixel(8'd35, 1'b1);
    send_pixel(8'd36, 1'b1);
    stop_pixels();
    drain();

    steady = 1'b1;
    configure(16, 1, 16, 8);
    send_frame(128, 1'b1, 1'b0, 128);
    steady = 1'b0;

    hold_rx = 1'b1;
    configure(16, 1, 16, 8);
    send_frame(96, 1'b1, 1'b0, 96);

    // A 16 by 16 block, mostly white, so the column sum runs high.
    configure(16, 16, 1, 0);
    for (int k = 0; k < 256; k++) begin
      send_pixel((k % 97 == 5) ? GRAY_W'($urandom_range(255)) : 8'd255, k == 0);
    end
    stop_pixels();
    drain();

    configure(8191, 1, 511, 2047);
    send_frame(100, 1'b1, 1'b0, 100);

    used_items = 0;
    while (used_items < RANDOM_ITEMS) begin
      iw = $urandom_range(1, 12);
      if ($urandom_range(9) == 0) iw = 0;
      r = $urandom_range(19);
      bs = (r == 0) ? 0 : (r == 1) ? $urandom_range(65, 127) : $urandom_range(1, 4);
      r = $urandom_range(9);
      cols = (r == 0) ? 0 : (r == 1) ? $urandom_range(257, 511) : $urandom_range(1, 5);
      r = $urandom_range(9);
      rows = (r == 0) ? 0 : (r == 1) ? $urandom_range(1025, 2047) : $urandom_range(1, 4);
      configure(iw, bs, cols, rows);
      count = ((iw == 0) ? 1 : iw) * ((bs == 0) ? 1 : (bs > 64) ? 64 : bs) *
              ((rows == 0) ? 1 : (rows > 4) ? 4 : rows) + $urandom_range(0, 4);
      if (count > 120) count = 120;
      send_frame(count, $urandom_range(7) != 0, 1'b1,
                 ($urandom_range(3) == 0) ? count / 2 : count);
    end

    board.close_out();
    if (board.errors == 0) begin
      $display("box_average_ascii_art_mapper_tb: clean");
    end else begin
      $display("box_average_ascii_art_mapper_tb: errors");
    end
    $finish;
  end

endmodule
